// ===== rtl/free_cell_set_swap_remove_macros.svh =====
// Assertion helpers for the checker file.
`ifndef FREE_CELL_SET_SWAP_REMOVE_MACROS_SVH
`define FREE_CELL_SET_SWAP_REMOVE_MACROS_SVH

// Clocked property, ignored while reset is high.
`define FCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that is also checked across reset.
`define FCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcs_pkg;

   // field widths
   localparam int MODE_W      = 2;
   localparam int POS_W       = 6;
   localparam int SLOT_W      = 12;
   localparam int FREE_W      = 13;
   localparam int STATUS_W    = 2;
   localparam int CFG_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int CFG_MAX     = 127;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OCCUPY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   typedef struct packed {
      logic                accept;
      logic                rebuild_start;
      logic                walk_step;
      logic                occ_lookup;
      logic                occ_follow;
      logic                occ_commit;
      logic                read_issue;
      logic                read_capture;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              grid_empty;
      logic              walk_last;
      logic              occ_range;
      logic              read_range;
      logic              occ_hit;
      logic              out_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/fcs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire fcs_pkg::dp_stat_type stat,
   output fcs_pkg::dp_cmd_type      cmd
);

   import fcs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_OCC_FOLLOW,
      ST_OCC_CHECK,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.mode)
               MODE_REBUILD: begin
                  cmd.rebuild_start = 1'b1;
                  state_in = stat.grid_empty ? ST_FINISH : ST_WALK;
               end
               MODE_OCCUPY: begin
                  if (stat.occ_range) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_RANGE;
                     state_in       = ST_FINISH;
                  end else begin
                     cmd.occ_lookup = 1'b1;
                     state_in       = ST_OCC_FOLLOW;
                  end
               end
               MODE_READ: begin
                  if (stat.read_range) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_RANGE;
                     state_in       = ST_FINISH;
                  end else begin
                     cmd.read_issue = 1'b1;
                     state_in       = ST_READ_WAIT;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_OCC_FOLLOW: begin
            cmd.occ_follow = 1'b1;
            state_in       = ST_OCC_CHECK;
         end
         ST_OCC_CHECK: begin
            if (stat.occ_hit) begin
               cmd.occ_commit = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = STATUS_OCCUPIED;
            end
            state_in = ST_FINISH;
         end
         ST_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/fcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcs_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   input  wire logic [fcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [fcs_pkg::CFG_W-1:0]             csr_data,
   input  wire logic [fcs_pkg::MODE_W-1:0]            req_tuser,
   input  wire logic [fcs_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [fcs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic      [fcs_pkg::STATUS_W-1:0]          rsp_tuser,
   input  wire fcs_pkg::dp_cmd_type                   cmd,
   output fcs_pkg::dp_stat_type                       stat
);

   import fcs_pkg::*;

   localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;
   localparam int AW  = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
   localparam int FW  = $clog2(CELL_TOTAL + 1);
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int PW  = RW + CW;
   localparam int RUW = $clog2((MAX_ROWS > CFG_MAX ? MAX_ROWS : CFG_MAX) + 1);
   localparam int CUW = $clog2((MAX_COLS > CFG_MAX ? MAX_COLS : CFG_MAX) + 1);
   localparam int SW  = (FW > SLOT_W) ? FW : SLOT_W;
   localparam int PAD_W = RSP_DATA_W - 2 * POS_W - FREE_W;

   // configuration
   logic [CFG_W-1:0]    row_count_ff, row_count_in;
   logic [CFG_W-1:0]    col_count_ff, col_count_in;
   // latched item
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [POS_W-1:0]    row_ff, row_in;
   logic [POS_W-1:0]    col_ff, col_in;
   logic [SLOT_W-1:0]   slot_idx_ff, slot_idx_in;
   // set state and walk counters
   logic [FW-1:0]       free_ff, free_in;
   logic [RUW-1:0]      walk_r_ff, walk_r_in;
   logic [CUW-1:0]      walk_c_ff, walk_c_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [PW-1:0]       moved_ff, moved_in;
   // result under construction and output register
   logic [RW-1:0]       res_row_ff, res_row_in;
   logic [CW-1:0]       res_col_ff, res_col_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [STATUS_W-1:0] out_user_ff, out_user_in;

   logic [RUW-1:0]      rows_use;
   logic [CUW-1:0]      cols_use;
   logic [AW-1:0]       item_addr, moved_addr, walk_addr, last_slot;
   logic [PW-1:0]       item_pair;
   logic [FW-1:0]       free_less;

   // slot_of_cell: cell address -> slot
   logic            sc_wr_en;
   logic [AW-1:0]   sc_wr_addr, sc_wr_data, sc_rd_data;
   // cell_of_slot: slot -> {row, col}
   logic            cs_wr_en;
   logic [AW-1:0]   cs_wr_addr, cs_rd_addr;
   logic [PW-1:0]   cs_wr_data, cs_rd_data;

   always_comb begin
      rows_use = (RUW'(row_count_ff) > RUW'(MAX_ROWS)) ? RUW'(MAX_ROWS) : RUW'(row_count_ff);
      cols_use = (CUW'(col_count_ff) > CUW'(MAX_COLS)) ? CUW'(MAX_COLS) : CUW'(col_count_ff);
      item_pair  = {RW'(row_ff), CW'(col_ff)};
      item_addr  = AW'(AW'(RW'(row_ff)) * AW'(MAX_COLS)) + AW'(CW'(col_ff));
      moved_addr = AW'(AW'(moved_ff[PW-1:CW]) * AW'(MAX_COLS)) + AW'(moved_ff[CW-1:0]);
      walk_addr  = AW'(AW'(RW'(walk_r_ff)) * AW'(MAX_COLS)) + AW'(CW'(walk_c_ff));
      free_less  = free_ff - FW'(1);
      last_slot  = AW'(free_less);
   end

   always_comb begin
      stat.mode       = mode_ff;
      stat.grid_empty = (rows_use == '0) || (cols_use == '0);
      stat.walk_last  = (walk_c_ff + CUW'(1) == cols_use) && (walk_r_ff + RUW'(1) == rows_use);
      stat.occ_range  = (RUW'(row_ff) >= rows_use) || (CUW'(col_ff) >= cols_use);
      stat.read_range = (SW'(slot_idx_ff) >= SW'(free_ff))
                        || (SW'(slot_idx_ff) >= SW'(CELL_TOTAL));
      stat.occ_hit    = (FW'(slot_ff) < free_ff) && (cs_rd_data == item_pair);
      stat.out_busy   = out_valid_ff && !rsp_tready;
   end

   // memory ports
   always_comb begin
      sc_wr_en   = 1'b0;
      sc_wr_addr = walk_addr;
      sc_wr_data = AW'(free_ff);
      cs_wr_en   = 1'b0;
      cs_wr_addr = AW'(free_ff);
      cs_wr_data = {RW'(walk_r_ff), CW'(walk_c_ff)};
      if (cmd.walk_step) begin
         sc_wr_en = 1'b1;
         cs_wr_en = 1'b1;
      end else if (cmd.occ_commit && (FW'(slot_ff) != free_less)) begin
         // last listed cell moves into the freed slot
         sc_wr_en   = 1'b1;
         sc_wr_addr = moved_addr;
         sc_wr_data = slot_ff;
         cs_wr_en   = 1'b1;
         cs_wr_addr = slot_ff;
         cs_wr_data = moved_ff;
      end
      priority if (cmd.occ_lookup) begin
         cs_rd_addr = last_slot;
      end else if (cmd.occ_follow) begin
         cs_rd_addr = sc_rd_data;
      end else begin
         cs_rd_addr = AW'(slot_idx_ff);
      end
   end

   fcs_ram #(.WIDTH(AW), .DEPTH(CELL_TOTAL)) u_slot_of_cell (
      .clock   (clock),
      .wr_en   (sc_wr_en),
      .wr_addr (sc_wr_addr),
      .wr_data (sc_wr_data),
      .rd_addr (item_addr),
      .rd_data (sc_rd_data)
   );

   fcs_ram #(.WIDTH(PW), .DEPTH(CELL_TOTAL)) u_cell_of_slot (
      .clock   (clock),
      .wr_en   (cs_wr_en),
      .wr_addr (cs_wr_addr),
      .wr_data (cs_wr_data),
      .rd_addr (cs_rd_addr),
      .rd_data (cs_rd_data)
   );

   always_comb begin
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      mode_in       = mode_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      slot_idx_in   = slot_idx_ff;
      free_in       = free_ff;
      walk_r_in     = walk_r_ff;
      walk_c_in     = walk_c_ff;
      slot_in       = slot_ff;
      moved_in      = moved_ff;
      res_row_in    = res_row_ff;
      res_col_in    = res_col_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_user_in   = out_user_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_data;
            CSR_COL_COUNT: col_count_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         mode_in       = req_tuser;
         row_in        = req_tdata[POS_W-1:0];
         col_in        = req_tdata[2*POS_W-1:POS_W];
         slot_idx_in   = req_tdata[2*POS_W+SLOT_W-1:2*POS_W];
         res_row_in    = '0;
         res_col_in    = '0;
         res_status_in = STATUS_OK;
      end

      if (cmd.rebuild_start) begin
         free_in   = '0;
         walk_r_in = '0;
         walk_c_in = '0;
      end

      if (cmd.walk_step) begin
         free_in = free_ff + FW'(1);
         if (walk_c_ff + CUW'(1) == cols_use) begin
            walk_c_in = '0;
            walk_r_in = walk_r_ff + RUW'(1);
         end else begin
            walk_c_in = walk_c_ff + CUW'(1);
         end
      end

      if (cmd.occ_follow) begin
         slot_in  = sc_rd_data;
         moved_in = cs_rd_data;
      end

      if (cmd.occ_commit) begin
         free_in = free_less;
      end

      if (cmd.read_capture) begin
         res_row_in = cs_rd_data[PW-1:CW];
         res_col_in = cs_rd_data[CW-1:0];
      end

      if (cmd.set_status) begin
         res_status_in = cmd.status;
      end

      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = {PAD_W'(0), FREE_W'(free_ff), POS_W'(res_col_ff), POS_W'(res_row_ff)};
         out_user_in  = res_status_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CFG_RESET;
         col_count_ff <= CFG_RESET;
         free_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      slot_idx_ff   <= slot_idx_in;
      walk_r_ff     <= walk_r_in;
      walk_c_ff     <= walk_c_in;
      slot_ff       <= slot_in;
      moved_ff      <= moved_in;
      res_row_ff    <= res_row_in;
      res_col_ff    <= res_col_in;
      res_status_ff <= res_status_in;
      out_data_ff   <= out_data_in;
      out_user_ff   <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

// ===== rtl/free_cell_set_swap_remove.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// req_      in         tuser: mode; tdata: cell_row, cell_col, slot_index
// rsp_      out        tuser: status; tdata: out_row, out_col, free_total
// csr_      in         csr_index selects row_count (0) or col_count (1)
//
// Rebuild writes one grid cell per cycle on the single write port of each
// table. Reset is synchronous; the tables hold no reset value and need no
// clearing pass, the free count resets to zero. A stalled response holds
// the next result in the finish state; one request may be accepted while a
// response waits.

module free_cell_set_swap_remove #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [23:12] slot_index, [11:6] cell_col, [5:0] cell_row
   input  wire logic [fcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] mode
   input  wire logic [fcs_pkg::MODE_W-1:0]         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:25] zero, [24:12] free_total, [11:6] out_col, [5:0] out_row
   output logic      [fcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic      [fcs_pkg::STATUS_W-1:0]       rsp_tuser,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [fcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fcs_pkg::CFG_W-1:0]          csr_data
);

   import fcs_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   fcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fcs_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

// ===== rtl/fcs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "free_cell_set_swap_remove_macros.svh"

module fcs_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [fcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [fcs_pkg::STATUS_W-1:0]   rsp_tuser
);

   import fcs_pkg::*;

   // one transaction in flight: busy right after an accept
   `FCS_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "request accepted while previous one still in work")

   // error responses carry no coordinates
   `FCS_ASSERT(a_error_no_coord, clock, reset, (rsp_tvalid && (rsp_tuser != STATUS_OK)) |-> (rsp_tdata[2*POS_W-1:0] == '0), "error response with nonzero coordinates")

   `FCS_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled response changed")

   `FCS_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind free_cell_set_swap_remove fcs_checker u_fcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
